/* src/pcdp_pkg.sv */
// Package for the phase-coded complex dot-product engine.
// Holds item modes, weight codes, field widths and parameter defaults.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pcdp_pkg;

  // default widths of the arithmetic
  localparam int ACT_WIDTH_DEF   = 16;
  localparam int SCALE_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF   = 48;

  // fixed field widths
  localparam int MODE_WIDTH  = 2;
  localparam int SLOT_WIDTH  = 3;
  localparam int LOAD_WIDTH  = 48;
  localparam int CODES_WIDTH = 8;
  localparam int CODE_WIDTH  = 2;

  localparam int NUM_MATRICES = 4;
  localparam int NUM_SCALES   = 2 * NUM_MATRICES;

  // result queue depth, must cover every result still in the pipeline
  localparam int QUEUE_DEPTH = 8;

  // item modes
  localparam logic [MODE_WIDTH-1:0] MODE_LOAD_SCALE = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_LOAD_BIAS  = 2'd1;
  localparam logic [MODE_WIDTH-1:0] MODE_MAC        = 2'd2;

  // bias slots
  localparam logic [SLOT_WIDTH-1:0] SLOT_BIAS_REAL = 3'd0;
  localparam logic [SLOT_WIDTH-1:0] SLOT_BIAS_IMAG = 3'd1;

  // weight codes
  localparam logic [CODE_WIDTH-1:0] CODE_NEG_REAL = 2'd0;
  localparam logic [CODE_WIDTH-1:0] CODE_POS_REAL = 2'd1;
  localparam logic [CODE_WIDTH-1:0] CODE_NEG_IMAG = 2'd2;
  localparam logic [CODE_WIDTH-1:0] CODE_POS_IMAG = 2'd3;

endpackage

`default_nettype wire

/* src/pcdp_if.sv */
// Valid/ready channel interfaces of the phase-coded dot-product engine.
// Depends on pcdp_pkg for field widths and width defaults.
`default_nettype none

interface pcdp_in_if import pcdp_pkg::*; #(
  parameter int ACT_WIDTH = ACT_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic [MODE_WIDTH-1:0]        mode;
  logic [SLOT_WIDTH-1:0]        slot;
  logic signed [LOAD_WIDTH-1:0] load_value;
  logic signed [ACT_WIDTH-1:0]  act_real;
  logic signed [ACT_WIDTH-1:0]  act_imag;
  logic [CODES_WIDTH-1:0]       codes;
  logic                         last;

  modport source (
    output valid, mode, slot, load_value, act_real, act_imag, codes, last,
    input  ready
  );
  modport sink (
    input  valid, mode, slot, load_value, act_real, act_imag, codes, last,
    output ready
  );
endinterface

interface pcdp_out_if import pcdp_pkg::*; #(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] real_sum;
  logic signed [ACC_WIDTH-1:0] imag_sum;

  modport source (output valid, real_sum, imag_sum, input ready);
  modport sink   (input valid, real_sum, imag_sum, output ready);
endinterface

`default_nettype wire

/* src/phase_code_complex_dot_product.sv */
// Phase-coded complex dot-product engine: top level.
// Depends on pcdp_pkg and the channel interfaces in pcdp_if.sv.
//
// Usage:
//  - item channel (valid/ready): one item per transfer. Mode 0 loads a scale
//    into one of eight slots, mode 1 loads the real or imaginary bias, mode 2
//    multiplies one complex activation by the four coded weights and adds it
//    to the running real and imaginary sums. Mode 3 items are dropped.
//  - result channel (valid/ready): one result per mode 2 item marked last,
//    the sums plus bias saturated to ACC_WIDTH bits; the sums then restart.
//  - throughput: one item per cycle while the item channel is ready (see
//    stalls). The only loop is the saturating accumulator add.
//  - path: input register, coefficient register, product register,
//    accumulator, bias add into the result queue, in that order; a result
//    can be taken once its last element has passed through all of them.
//  - stalls: finished results wait in an 8-entry queue. The item channel
//    stays ready as long as the queue plus the results still in the
//    pipeline leave room, so items keep flowing while the receiver stalls
//    until the queue and the pipeline together hold eight results.
//  - reset (rst, synchronous): scales, biases and sums go to zero, the
//    pipeline and the queue empty. No warm-up time is needed after reset.
`default_nettype none

module phase_code_complex_dot_product import pcdp_pkg::*; #(
  parameter int ACT_WIDTH   = ACT_WIDTH_DEF,
  parameter int SCALE_WIDTH = SCALE_WIDTH_DEF,
  parameter int ACC_WIDTH   = ACC_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pcdp_in_if.sink   item,
  pcdp_out_if.source result
);

  // coefficient: sum of four scales, each possibly negated
  localparam int CW  = SCALE_WIDTH + 3;
  localparam int PW  = ACT_WIDTH + CW;
  localparam int SW  = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 2;
  localparam int BW  = ACC_WIDTH + 1;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int INF_W = CNT_W + 1;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // ---------------- stage a: input register ----------------
  logic                         a_valid;
  logic [MODE_WIDTH-1:0]        a_mode;
  logic [SLOT_WIDTH-1:0]        a_slot;
  logic signed [LOAD_WIDTH-1:0] a_load;
  logic signed [ACT_WIDTH-1:0]  a_act_r;
  logic signed [ACT_WIDTH-1:0]  a_act_i;
  logic [CODES_WIDTH-1:0]       a_codes;
  logic                         a_last;
  logic                         a_mac;

  logic item_xfer;
  logic credit_ok;

  assign item_xfer  = item.valid && item.ready;
  assign item.ready = credit_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= item_xfer;
    end
    if (item_xfer) begin
      a_mode  <= item.mode;
      a_slot  <= item.slot;
      a_load  <= item.load_value;
      a_act_r <= item.act_real;
      a_act_i <= item.act_imag;
      a_codes <= item.codes;
      a_last  <= item.last;
    end
  end

  assign a_mac = a_valid && (a_mode == MODE_MAC);

  // scale bank and bias, written in item order from stage a
  logic signed [SCALE_WIDTH-1:0] scale_bank [NUM_SCALES];
  logic signed [ACC_WIDTH-1:0]   bias_real;
  logic signed [ACC_WIDTH-1:0]   bias_imag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SCALES; i++) begin
        scale_bank[i] <= '0;
      end
      bias_real <= '0;
      bias_imag <= '0;
    end else if (a_valid) begin
      if (a_mode == MODE_LOAD_SCALE) begin
        scale_bank[a_slot] <= a_load[SCALE_WIDTH-1:0];
      end
      if (a_mode == MODE_LOAD_BIAS && a_slot == SLOT_BIAS_REAL) begin
        bias_real <= ACC_WIDTH'(a_load);
      end
      if (a_mode == MODE_LOAD_BIAS && a_slot == SLOT_BIAS_IMAG) begin
        bias_imag <= ACC_WIDTH'(a_load);
      end
    end
  end

  // decode the four codes into real and imaginary terms
  logic signed [CW-1:0] re_term [NUM_MATRICES];
  logic signed [CW-1:0] im_term [NUM_MATRICES];
  logic signed [CW-1:0] cxr_re, cxi_re, cxr_im, cxi_im;

  always_comb begin
    for (int k = 0; k < NUM_MATRICES; k++) begin
      re_term[k] = '0;
      im_term[k] = '0;
      case (a_codes[CODE_WIDTH*k +: CODE_WIDTH])
        CODE_NEG_REAL: re_term[k] = -CW'(scale_bank[2*k]);
        CODE_POS_REAL: re_term[k] = CW'(scale_bank[2*k]);
        CODE_NEG_IMAG: im_term[k] = -CW'(scale_bank[2*k+1]);
        default:       im_term[k] = CW'(scale_bank[2*k+1]);
      endcase
    end
    // matrix order: u0, u1, w0, w1
    cxr_re = re_term[0] + re_term[1] + re_term[2] + re_term[3];
    cxi_re = -im_term[0] - im_term[1] + im_term[2] + im_term[3];
    cxr_im = im_term[0] + im_term[1] + im_term[2] + im_term[3];
    cxi_im = re_term[0] + re_term[1] - re_term[2] - re_term[3];
  end

  // ---------------- stage b: coefficient register ----------------
  logic                        b_valid;
  logic                        b_last;
  logic signed [ACT_WIDTH-1:0] b_act_r, b_act_i;
  logic signed [CW-1:0]        b_cxr_re, b_cxi_re, b_cxr_im, b_cxi_im;
  logic signed [ACC_WIDTH-1:0] b_bias_r, b_bias_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_mac;
    end
    b_last   <= a_last;
    b_act_r  <= a_act_r;
    b_act_i  <= a_act_i;
    b_cxr_re <= cxr_re;
    b_cxi_re <= cxi_re;
    b_cxr_im <= cxr_im;
    b_cxi_im <= cxi_im;
    // bias as seen by this row's last element
    b_bias_r <= bias_real;
    b_bias_i <= bias_imag;
  end

  // ---------------- stage c: product register ----------------
  logic                        c_valid;
  logic                        c_last;
  logic signed [PW-1:0]        c_p_rr, c_p_ri, c_p_ir, c_p_ii;
  logic signed [ACC_WIDTH-1:0] c_bias_r, c_bias_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    c_last   <= b_last;
    c_p_rr   <= PW'(b_act_r) * PW'(b_cxr_re);
    c_p_ri   <= PW'(b_act_i) * PW'(b_cxi_re);
    c_p_ir   <= PW'(b_act_r) * PW'(b_cxr_im);
    c_p_ii   <= PW'(b_act_i) * PW'(b_cxi_im);
    c_bias_r <= b_bias_r;
    c_bias_i <= b_bias_i;
  end

  // ---------------- stage d: saturating accumulators ----------------
  logic signed [ACC_WIDTH-1:0] acc_real, acc_imag;
  logic signed [SW-1:0]        wide_r, wide_i;
  logic signed [ACC_WIDTH-1:0] sat_r, sat_i;

  always_comb begin
    wide_r = SW'(acc_real) + SW'(c_p_rr) + SW'(c_p_ri);
    wide_i = SW'(acc_imag) + SW'(c_p_ir) + SW'(c_p_ii);
    // in range when the result's sign bit and all bits above it agree
    if ((&wide_r[SW-1:ACC_WIDTH-1]) || !(|wide_r[SW-1:ACC_WIDTH-1])) begin
      sat_r = wide_r[ACC_WIDTH-1:0];
    end else begin
      sat_r = wide_r[SW-1] ? ACC_MIN : ACC_MAX;
    end
    if ((&wide_i[SW-1:ACC_WIDTH-1]) || !(|wide_i[SW-1:ACC_WIDTH-1])) begin
      sat_i = wide_i[ACC_WIDTH-1:0];
    end else begin
      sat_i = wide_i[SW-1] ? ACC_MIN : ACC_MAX;
    end
  end

  logic                        e_valid;
  logic signed [ACC_WIDTH-1:0] e_acc_r, e_acc_i;
  logic signed [ACC_WIDTH-1:0] e_bias_r, e_bias_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_real <= '0;
      acc_imag <= '0;
      e_valid  <= 1'b0;
    end else begin
      e_valid <= c_valid && c_last;
      if (c_valid) begin
        // last element closes the row and restarts the sums
        acc_real <= c_last ? '0 : sat_r;
        acc_imag <= c_last ? '0 : sat_i;
      end
    end
    e_acc_r  <= sat_r;
    e_acc_i  <= sat_i;
    e_bias_r <= c_bias_r;
    e_bias_i <= c_bias_i;
  end

  // ---------------- stage e: bias add into the result queue ----------------
  logic signed [BW-1:0]        fin_wide_r, fin_wide_i;
  logic signed [ACC_WIDTH-1:0] fin_r, fin_i;

  always_comb begin
    fin_wide_r = BW'(e_acc_r) + BW'(e_bias_r);
    fin_wide_i = BW'(e_acc_i) + BW'(e_bias_i);
    if (fin_wide_r[BW-1] == fin_wide_r[BW-2]) begin
      fin_r = fin_wide_r[ACC_WIDTH-1:0];
    end else begin
      fin_r = fin_wide_r[BW-1] ? ACC_MIN : ACC_MAX;
    end
    if (fin_wide_i[BW-1] == fin_wide_i[BW-2]) begin
      fin_i = fin_wide_i[ACC_WIDTH-1:0];
    end else begin
      fin_i = fin_wide_i[BW-1] ? ACC_MIN : ACC_MAX;
    end
  end

  logic signed [ACC_WIDTH-1:0] q_real [QUEUE_DEPTH];
  logic signed [ACC_WIDTH-1:0] q_imag [QUEUE_DEPTH];
  logic [PTR_W-1:0]            wr_ptr, rd_ptr;
  logic [CNT_W-1:0]            q_count;
  logic                        result_xfer;

  assign result_xfer     = result.valid && result.ready;
  assign result.valid    = (q_count != '0);
  assign result.real_sum = q_real[rd_ptr];
  assign result.imag_sum = q_imag[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (e_valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (result_xfer) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (e_valid && !result_xfer) begin
        q_count <= q_count + 1'b1;
      end else if (!e_valid && result_xfer) begin
        q_count <= q_count - 1'b1;
      end
    end
    if (e_valid) begin
      q_real[wr_ptr] <= fin_r;
      q_imag[wr_ptr] <= fin_i;
    end
  end

  // results still in flight reserve their queue entries
  logic [INF_W-1:0] in_flight;

  assign in_flight = INF_W'(q_count)
                   + INF_W'(a_mac && a_last)
                   + INF_W'(b_valid && b_last)
                   + INF_W'(c_valid && c_last)
                   + INF_W'(e_valid);
  assign credit_ok = (in_flight < INF_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire
